// ----- src/ifs_pkg.sv -----
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared widths, types and register indexes of the two-channel frequency
// statistics block.
// ----------------------------------------------------------------------------
package ifs_pkg;

   localparam int CODE_W  = 24;
   localparam int CLK_W   = 25;
   localparam int DIVL_W  = 2;
   localparam int FREQ_W  = 32;
   localparam int CNT_W   = 32;
   localparam int SUM_W   = 64;
   localparam int PROD_W  = CODE_W + CLK_W;
   localparam int MSTEP_W = $clog2(CODE_W);
   localparam int DSTEP_W = $clog2(SUM_W);
   localparam int CSR_W   = CLK_W;
   localparam int CIDX_W  = 1;

   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [CLK_W-1:0]   clk_type;
   typedef logic [DIVL_W-1:0]  divl_type;
   typedef logic [FREQ_W-1:0]  freq_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [CSR_W-1:0]   csr_type;
   typedef logic [CIDX_W-1:0]  cidx_type;

   localparam cidx_type CSR_REF_CLOCK = cidx_type'(0);
   localparam cidx_type CSR_DIV_LOG2  = cidx_type'(1);

   localparam clk_type  REF_CLOCK_RST = clk_type'(16000000);
   localparam divl_type DIV_LOG2_RST  = divl_type'(0);

endpackage

// ----- src/ifs_mul.sv -----
// ----------------------------------------------------------------------------
// ifs_mul
// Bit-serial shift-add multiplier: code times reference clock, one code bit
// per cycle, LSB first.
// ----------------------------------------------------------------------------
module ifs_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ifs_pkg::code_type  code,
   input  ifs_pkg::clk_type   multiplicand,
   output logic               done,
   output ifs_pkg::prod_type  product
);

   localparam int ACC_W = ifs_pkg::CLK_W + 1 + ifs_pkg::CODE_W;
   localparam int HI_W  = ifs_pkg::CLK_W + 1;
   localparam logic [ifs_pkg::MSTEP_W-1:0] LAST_STEP =
      (ifs_pkg::MSTEP_W)'(ifs_pkg::CODE_W - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [ifs_pkg::MSTEP_W-1:0] step_ff, step_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   ifs_pkg::clk_type            mcand_ff, mcand_in;
   logic [HI_W-1:0]             hi_sum;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      hi_sum   = acc_ff[ACC_W-1:ifs_pkg::CODE_W] +
                 (acc_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         acc_in   = {{HI_W{1'b0}}, code};
         mcand_in = multiplicand;
      end else if (busy_ff) begin
         acc_in  = {1'b0, hi_sum, acc_ff[ifs_pkg::CODE_W-1:1]};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[ifs_pkg::PROD_W-1:0];

endmodule

// ----- src/ifs_div.sv -----
// ----------------------------------------------------------------------------
// ifs_div
// Restoring divider, one quotient bit per cycle: 64-bit sum over 32-bit
// count, quotient clamped to all ones above 32 bits.
// ----------------------------------------------------------------------------
module ifs_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ifs_pkg::sum_type   dividend,
   input  ifs_pkg::cnt_type   divisor,
   output logic               done,
   output ifs_pkg::freq_type  quotient
);

   localparam logic [ifs_pkg::DSTEP_W-1:0] LAST_STEP =
      (ifs_pkg::DSTEP_W)'(ifs_pkg::SUM_W - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [ifs_pkg::DSTEP_W-1:0] step_ff, step_in;
   ifs_pkg::cnt_type            rem_ff, rem_in;
   ifs_pkg::sum_type            quo_ff, quo_in;
   ifs_pkg::cnt_type            dsor_ff, dsor_in;
   logic [ifs_pkg::CNT_W:0]     shifted;
   logic [ifs_pkg::CNT_W:0]     diff;
   logic                        geq;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      shifted = {rem_ff, quo_ff[ifs_pkg::SUM_W-1]};
      diff    = shifted - {1'b0, dsor_ff};
      geq     = (shifted >= {1'b0, dsor_ff});
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = geq ? diff[ifs_pkg::CNT_W-1:0] : shifted[ifs_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[ifs_pkg::SUM_W-2:0], geq};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[ifs_pkg::SUM_W-1:ifs_pkg::FREQ_W]) ? '1 :
                     quo_ff[ifs_pkg::FREQ_W-1:0];

endmodule

// ----- src/inductive_freq_stats_two_channel.sv -----
// ----------------------------------------------------------------------------
// inductive_freq_stats_two_channel
// Scales 24-bit sensor codes to whole-Hz frequencies and keeps running
// min / max / sum / count per channel, reporting the mean and total count.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  clear, channel, valid, code
//   rsp_      out        rsp_valid/rsp_stall  accepted, freq, min, max, mean,
//                                             counts
//   csr_      in         csr_wr_en            index, data (no read-back)
//
// Valid sample: serial multiply, serial divide and control states, all finished
// before the next item is accepted. An invalid sample skips the multiply; a
// clear, or an invalid sample on an empty channel, skips the divide too.
// req_stall is high while an item is in work; a finished result waits in the
// output register, so rsp_stall only holds back the item after it.
// Synchronous reset clears statistics and restores register defaults.
// ----------------------------------------------------------------------------
module inductive_freq_stats_two_channel (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_clear_stats,
   input  logic                req_channel,
   input  logic                req_sample_valid,
   input  ifs_pkg::code_type   req_raw_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_accepted,
   output ifs_pkg::freq_type   rsp_frequency_hz,
   output ifs_pkg::freq_type   rsp_channel_min,
   output ifs_pkg::freq_type   rsp_channel_max,
   output ifs_pkg::freq_type   rsp_channel_mean,
   output ifs_pkg::cnt_type    rsp_channel_count,
   output ifs_pkg::cnt_type    rsp_total_count,
   input  logic                csr_wr_en,
   input  ifs_pkg::cidx_type   csr_index,
   input  ifs_pkg::csr_type    csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_DIVGO = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_HOLD  = 3'd5;

   localparam int SH_W = ifs_pkg::PROD_W + (1 << ifs_pkg::DIVL_W) - 1;

   logic [2:0]          state_ff, state_in;
   ifs_pkg::clk_type    ref_clk_ff, ref_clk_in;
   ifs_pkg::divl_type   div_log2_ff, div_log2_in;

   logic                clr_ff, clr_in;
   logic                ch_ff, ch_in;
   logic                vld_ff, vld_in;
   ifs_pkg::freq_type   freq_ff, freq_in;
   ifs_pkg::freq_type   mean_ff, mean_in;

   ifs_pkg::freq_type   min_ff [2];
   ifs_pkg::freq_type   min_in [2];
   ifs_pkg::freq_type   max_ff [2];
   ifs_pkg::freq_type   max_in [2];
   ifs_pkg::sum_type    sum_ff [2];
   ifs_pkg::sum_type    sum_in [2];
   ifs_pkg::cnt_type    cnt_ff [2];
   ifs_pkg::cnt_type    cnt_in [2];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff, rsp_acc_in;
   ifs_pkg::freq_type   rsp_freq_ff, rsp_freq_in;
   ifs_pkg::freq_type   rsp_min_ff, rsp_min_in;
   ifs_pkg::freq_type   rsp_max_ff, rsp_max_in;
   ifs_pkg::freq_type   rsp_mean_ff, rsp_mean_in;
   ifs_pkg::cnt_type    rsp_cnt_ff, rsp_cnt_in;
   ifs_pkg::cnt_type    rsp_tot_ff, rsp_tot_in;

   logic                req_fire;
   logic                rsp_fire;
   logic                mul_start;
   logic                mul_done;
   ifs_pkg::prod_type   mul_prod;
   logic [SH_W-1:0]     prod_sh;
   logic                div_start;
   logic                div_done;
   ifs_pkg::freq_type   div_quo;
   logic [ifs_pkg::SUM_W:0] sum_add;
   logic [ifs_pkg::CNT_W:0] tot_add;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign mul_start = req_fire && !req_clear_stats && req_sample_valid;
   assign div_start = (state_ff == S_DIVGO) && (cnt_ff[ch_ff] != '0);
   assign prod_sh   = {{(SH_W-ifs_pkg::PROD_W){1'b0}}, mul_prod} << div_log2_ff;
   assign sum_add   = {1'b0, sum_ff[ch_ff]} + {{(ifs_pkg::SUM_W+1-ifs_pkg::FREQ_W){1'b0}}, freq_ff};
   assign tot_add   = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};

   ifs_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .code         (req_raw_code),
      .multiplicand (ref_clk_ff),
      .done         (mul_done),
      .product      (mul_prod)
   );

   ifs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[ch_ff]),
      .divisor  (cnt_ff[ch_ff]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in    = state_ff;
      ref_clk_in  = ref_clk_ff;
      div_log2_in = div_log2_ff;
      clr_in      = clr_ff;
      ch_in       = ch_ff;
      vld_in      = vld_ff;
      freq_in     = freq_ff;
      mean_in     = mean_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_tot_in   = rsp_tot_ff;

      if (csr_wr_en) begin
         case (csr_index)
            ifs_pkg::CSR_REF_CLOCK: ref_clk_in  = csr_wdata;
            ifs_pkg::CSR_DIV_LOG2:  div_log2_in = csr_wdata[ifs_pkg::DIVL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               clr_in  = req_clear_stats;
               ch_in   = req_channel;
               vld_in  = req_sample_valid;
               freq_in = '0;
               state_in = mul_start ? S_MUL : S_UPD;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               freq_in  = ifs_pkg::freq_type'(prod_sh >> ifs_pkg::CODE_W);
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (clr_ff) begin
               for (int k = 0; k < 2; k++) begin
                  min_in[k] = '1;
                  max_in[k] = '0;
                  sum_in[k] = '0;
                  cnt_in[k] = '0;
               end
            end else if (vld_ff) begin
               if (freq_ff < min_ff[ch_ff]) min_in[ch_ff] = freq_ff;
               if (freq_ff > max_ff[ch_ff]) max_in[ch_ff] = freq_ff;
               sum_in[ch_ff] = sum_add[ifs_pkg::SUM_W] ? '1 :
                               sum_add[ifs_pkg::SUM_W-1:0];
               if (cnt_ff[ch_ff] != '1) cnt_in[ch_ff] = cnt_ff[ch_ff] + 1'b1;
            end
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            mean_in  = '0;
            state_in = div_start ? S_DIV : S_HOLD;
         end
         S_DIV: begin
            if (div_done) begin
               mean_in  = div_quo;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = !clr_ff && vld_ff;
               rsp_freq_in  = freq_ff;
               rsp_min_in   = min_ff[ch_ff];
               rsp_max_in   = max_ff[ch_ff];
               rsp_mean_in  = mean_ff;
               rsp_cnt_in   = cnt_ff[ch_ff];
               rsp_tot_in   = tot_add[ifs_pkg::CNT_W] ? '1 :
                              tot_add[ifs_pkg::CNT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_clk_ff   <= ifs_pkg::REF_CLOCK_RST;
         div_log2_ff  <= ifs_pkg::DIV_LOG2_RST;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 2; k++) begin
            min_ff[k] <= '1;
            max_ff[k] <= '0;
            sum_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ref_clk_ff   <= ref_clk_in;
         div_log2_ff  <= div_log2_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
      end
      clr_ff      <= clr_in;
      ch_ff       <= ch_in;
      vld_ff      <= vld_in;
      freq_ff     <= freq_in;
      mean_ff     <= mean_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_tot_ff  <= rsp_tot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_frequency_hz  = rsp_freq_ff;
   assign rsp_channel_min   = rsp_min_ff;
   assign rsp_channel_max   = rsp_max_ff;
   assign rsp_channel_mean  = rsp_mean_ff;
   assign rsp_channel_count = rsp_cnt_ff;
   assign rsp_total_count   = rsp_tot_ff;

endmodule

// ----- src/ifs_checker.sv -----
// ----------------------------------------------------------------------------
// ifs_checker
// Port-level checks on the result channel of the frequency statistics block.
// ----------------------------------------------------------------------------
module ifs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_accepted,
   input ifs_pkg::freq_type  rsp_frequency_hz,
   input ifs_pkg::freq_type  rsp_channel_min,
   input ifs_pkg::freq_type  rsp_channel_max,
   input ifs_pkg::freq_type  rsp_channel_mean,
   input ifs_pkg::cnt_type   rsp_channel_count,
   input ifs_pkg::cnt_type   rsp_total_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frequency_hz)
         && $stable(rsp_channel_mean) && $stable(rsp_total_count))
      else $error("result item changed while stalled");

   a_no_freq_unaccepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_frequency_hz == '0)
      else $error("frequency reported for an item that was not taken");

   a_freq_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_channel_count != '0
         && rsp_channel_min <= rsp_frequency_hz
         && rsp_frequency_hz <= rsp_channel_max)
      else $error("accepted frequency outside channel min/max");

   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_count >= rsp_channel_count)
      else $error("total count below channel count");

   a_empty_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_count == '0 |-> rsp_channel_mean == '0
         && rsp_channel_min == '1 && rsp_channel_max == '0)
      else $error("empty channel shows statistics");

endmodule

bind inductive_freq_stats_two_channel ifs_checker u_ifs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_accepted      (rsp_accepted),
   .rsp_frequency_hz  (rsp_frequency_hz),
   .rsp_channel_min   (rsp_channel_min),
   .rsp_channel_max   (rsp_channel_max),
   .rsp_channel_mean  (rsp_channel_mean),
   .rsp_channel_count (rsp_channel_count),
   .rsp_total_count   (rsp_total_count)
);
